@@ src/rngqc_pkg.sv @@
// ----------------------------------------------------------------------------
// rngqc_pkg: shared types and constants of the RNG quality checker
// Field widths, register codes, the control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
package rngqc_pkg;

	// Fixed field widths
	localparam int SAMPLE_W   = 32;
	localparam int TOTAL_W    = 31;
	localparam int GAP_W      = 39;
	localparam int CHI_W      = 52;
	localparam int REG_W      = 7;
	localparam int APB_AW     = 4;
	localparam int APB_DW     = 32;
	localparam int M_TDATA_W  = 160;
	localparam int M_PAD_W    = M_TDATA_W - (2 * TOTAL_W + GAP_W + CHI_W);

	// Fixed-point fraction bits
	localparam int GAP_FRAC   = 8;
	localparam int CHI_FRAC   = 16;

	localparam logic [GAP_W-1:0] GAP_MAX = '1;
	localparam logic [CHI_W-1:0] CHI_MAX = '1;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_ALPHA = 2'd0;
	localparam logic [1:0] REG_PAT1  = 2'd1;
	localparam logic [1:0] REG_PAT2  = 2'd2;
	localparam logic [1:0] REG_PAT3  = 2'd3;

	localparam logic [REG_W-1:0] ALPHA_RST = 7'd26;
	localparam logic [REG_W-1:0] PAT1_RST  = 7'd3;
	localparam logic [REG_W-1:0] PAT2_RST  = 7'd1;
	localparam logic [REG_W-1:0] PAT3_RST  = 7'd20;

	// Control word
	typedef enum logic [2:0] {
		OP_NOP,
		OP_DIFF,
		OP_LOAD_CHI,
		OP_DIV,
		OP_SAVE_CHI,
		OP_LOAD_GAP,
		OP_SAVE_GAP,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_LL,
		MUL_HL,
		MUL_HH
	} mul_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LL,
		ACC_HL,
		ACC_HH
	} acc_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_BINS,
		JMP_DIV,
		JMP_OUT
	} jmp_t;

	localparam int PC_W = 4;

	typedef struct packed {
		op_t             op;
		mul_t            mul;
		acc_t            acc;
		jmp_t            jmp;
		logic [PC_W-1:0] tgt;
	} cw_t;

	// Program steps
	localparam logic [PC_W-1:0] PC_PRIME    = 4'd0;
	localparam logic [PC_W-1:0] PC_DIFF     = 4'd1;
	localparam logic [PC_W-1:0] PC_MUL_LL   = 4'd2;
	localparam logic [PC_W-1:0] PC_MUL_HL   = 4'd3;
	localparam logic [PC_W-1:0] PC_MUL_HH   = 4'd4;
	localparam logic [PC_W-1:0] PC_ACC_HH   = 4'd5;
	localparam logic [PC_W-1:0] PC_LOAD_CHI = 4'd6;
	localparam logic [PC_W-1:0] PC_DIV_CHI  = 4'd7;
	localparam logic [PC_W-1:0] PC_SAVE_CHI = 4'd8;
	localparam logic [PC_W-1:0] PC_LOAD_GAP = 4'd9;
	localparam logic [PC_W-1:0] PC_DIV_GAP  = 4'd10;
	localparam logic [PC_W-1:0] PC_SAVE_GAP = 4'd11;
	localparam logic [PC_W-1:0] PC_EMIT     = 4'd12;

	// Microcode ROM
	function automatic cw_t ucode(input logic [PC_W-1:0] pc);
		cw_t cw;
		cw = '{op: OP_NOP, mul: MUL_NONE, acc: ACC_NONE, jmp: JMP_NONE, tgt: '0};
		case (pc)
			PC_PRIME: begin
				cw.op = OP_NOP;
			end
			PC_DIFF: begin
				cw.op = OP_DIFF;
			end
			PC_MUL_LL: begin
				cw.mul = MUL_LL;
			end
			PC_MUL_HL: begin
				cw.mul = MUL_HL;
				cw.acc = ACC_LL;
			end
			PC_MUL_HH: begin
				cw.mul = MUL_HH;
				cw.acc = ACC_HL;
			end
			PC_ACC_HH: begin
				cw.acc = ACC_HH;
				cw.jmp = JMP_BINS;
				cw.tgt = PC_DIFF;
			end
			PC_LOAD_CHI: begin
				cw.op = OP_LOAD_CHI;
			end
			PC_DIV_CHI: begin
				cw.op  = OP_DIV;
				cw.jmp = JMP_DIV;
				cw.tgt = PC_DIV_CHI;
			end
			PC_SAVE_CHI: begin
				cw.op = OP_SAVE_CHI;
			end
			PC_LOAD_GAP: begin
				cw.op = OP_LOAD_GAP;
			end
			PC_DIV_GAP: begin
				cw.op  = OP_DIV;
				cw.jmp = JMP_DIV;
				cw.tgt = PC_DIV_GAP;
			end
			PC_SAVE_GAP: begin
				cw.op = OP_SAVE_GAP;
			end
			PC_EMIT: begin
				cw.op  = OP_EMIT;
				cw.jmp = JMP_OUT;
				cw.tgt = PC_EMIT;
			end
			default: begin
				cw.op = OP_NOP;
			end
		endcase
		return cw;
	endfunction

endpackage

@@ src/rng_quality_chi_square_cat_test_top.sv @@
// ----------------------------------------------------------------------------
// rng_quality_chi_square_cat_test_top: chi-square and pattern test on samples
// Samples arrive on the slave stream, one transfer per cycle, each binned into
// NUM_BINS equal bins and mapped to a letter ceil(A*u) for a three-letter
// pattern search. The transfer with tlast closes the run: the input stalls
// while a microcoded sequencer sums the squared bin deviations with a shared
// half-width multiplier and runs two bit-per-cycle divisions (chi-square, then
// mean gap) on a dividend of NUM_W = 2*(COUNT_BITS+clog2(NUM_BINS)) +
// clog2(NUM_BINS) + 16 bits. Before it emits, the sequencer waits for the
// output register to drain. The result transfer then holds on the master
// stream while the next run streams in. Bin counts are kept in a small memory
// with per-bin valid flags, so no clearing pass is needed between runs.
// ----------------------------------------------------------------------------
module rng_quality_chi_square_cat_test_top #(
	parameter int NUM_BINS    = 10,
	parameter int SAMPLE_BITS = 32,
	parameter int COUNT_BITS  = 31
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rngqc_pkg::APB_AW-1:0]        paddr,
	input  logic [rngqc_pkg::APB_DW-1:0]        pwdata,
	output logic [rngqc_pkg::APB_DW-1:0]        prdata,
	output logic                                pready,
	// samples
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [rngqc_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // sample[31:0]
	input  logic                                s_axis_tlast,  // last
	// results
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// sample_total[30:0], match_total[61:31], mean_gap[100:62],
	// chi_square[152:101], zero[159:153]
	output logic [rngqc_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

	localparam int SB    = SAMPLE_BITS;
	localparam int CW    = COUNT_BITS;
	localparam int IW    = $clog2(NUM_BINS);
	localparam int KB_W  = CW + IW;                  // NUM_BINS*count, |diff|
	localparam int HW    = (KB_W + 1) / 2;           // multiplier operand width
	localparam int SW    = 2 * KB_W + IW;            // sum of squares
	localparam int TW    = 4 * HW + SW;
	localparam int NUM_W = SW + rngqc_pkg::CHI_FRAC; // dividend width
	localparam int IT_W  = $clog2(NUM_W + 1);
	localparam int RW    = rngqc_pkg::REG_W;
	localparam int QW    = rngqc_pkg::CHI_W;
	localparam int GW    = rngqc_pkg::GAP_W;
	localparam int OW    = rngqc_pkg::TOTAL_W;

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
		return (&v) ? v : v + CW'(1);
	endfunction

	function automatic logic [OW-1:0] fit_total(input logic [CW-1:0] v);
		logic [CW+OW-1:0] t;
		t = {{OW{1'b0}}, v};
		return t[OW-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	logic [RW-1:0] alpha_q, pat1_q, pat2_q, pat3_q;
	logic          cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= rngqc_pkg::ALPHA_RST;
			pat1_q  <= rngqc_pkg::PAT1_RST;
			pat2_q  <= rngqc_pkg::PAT2_RST;
			pat3_q  <= rngqc_pkg::PAT3_RST;
		end else if (cfg_we) begin
			case (paddr[3:2])
				rngqc_pkg::REG_ALPHA: alpha_q <= pwdata[RW-1:0];
				rngqc_pkg::REG_PAT1:  pat1_q  <= pwdata[RW-1:0];
				rngqc_pkg::REG_PAT2:  pat2_q  <= pwdata[RW-1:0];
				rngqc_pkg::REG_PAT3:  pat3_q  <= pwdata[RW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			rngqc_pkg::REG_ALPHA: prdata = rngqc_pkg::APB_DW'(alpha_q);
			rngqc_pkg::REG_PAT1:  prdata = rngqc_pkg::APB_DW'(pat1_q);
			rngqc_pkg::REG_PAT2:  prdata = rngqc_pkg::APB_DW'(pat2_q);
			rngqc_pkg::REG_PAT3:  prdata = rngqc_pkg::APB_DW'(pat3_q);
			default:              prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// Per-sample path
	// ------------------------------------------------------------------------
	logic                       busy_q;
	logic                       s_fire;
	logic [SB+rngqc_pkg::SAMPLE_W-1:0] s_wide;
	logic [SB-1:0]              s_in;
	logic [SB+IW-1:0]           pb;
	logic [IW-1:0]              bin_in;
	logic [SB+RW-1:0]           pl;
	logic [RW-1:0]              letter;
	logic                       match;

	logic [CW-1:0]              samples_q, matches_q, first_q, latest_q;
	logic [RW-1:0]              prev_q, lbp_q;

	assign s_axis_tready = !busy_q;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	assign s_wide = {{SB{1'b0}}, s_axis_tdata};
	assign s_in   = s_wide[SB-1:0];
	assign pb     = (SB+IW)'(s_in) * (SB+IW)'(NUM_BINS);
	assign bin_in = pb[SB+IW-1:SB];
	assign pl     = (SB+RW)'(s_in) * (SB+RW)'(alpha_q);
	// ceil: round up whenever the fraction part is nonzero
	assign letter = pl[SB+RW-1:SB] + RW'(pl[SB-1:0] != '0);
	assign match  = (samples_q >= CW'(2)) && (lbp_q == pat1_q) &&
	                (prev_q == pat2_q) && (letter == pat3_q);

	// ------------------------------------------------------------------------
	// Bin count memory, one read port, write in the cycle after the transfer
	// ------------------------------------------------------------------------
	logic [CW-1:0]       bin_mem [NUM_BINS];
	logic [NUM_BINS-1:0] vld_q;
	logic [IW-1:0]       bin_s1;
	logic                wr_s1_q;
	logic [IW-1:0]       rd_addr;
	logic [CW-1:0]       mem_rd_q, byp_val_q;
	logic                byp_q, hit_q;
	logic [CW-1:0]       count_rd;
	logic [CW-1:0]       inc_s1;
	logic [IW-1:0]       bin_cnt_q;

	assign rd_addr  = busy_q ? bin_cnt_q : bin_in;
	assign count_rd = byp_q ? byp_val_q : (hit_q ? mem_rd_q : '0);
	assign inc_s1   = sat_inc(count_rd);

	always_ff @(posedge clk) begin
		if (wr_s1_q) begin
			bin_mem[bin_s1] <= inc_s1;
		end
		mem_rd_q  <= bin_mem[rd_addr];
		byp_val_q <= inc_s1;
		if (s_fire) begin
			bin_s1 <= bin_in;
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	rngqc_pkg::cw_t           cw;
	logic [rngqc_pkg::PC_W-1:0] pc_q;
	logic                     take;
	logic                     out_busy;
	logic                     emit_fire;
	logic                     last_bin_q;

	logic [KB_W-1:0]          kb, nn, diff_nx;
	logic [KB_W-1:0]          diff_q;
	logic [HW-1:0]            op_h, op_l, ma, mb;
	logic [2*HW-1:0]          prod_q;
	logic [TW-1:0]            term;
	logic [SW-1:0]            acc_q;

	logic [NUM_W-1:0]         num_q;
	logic [KB_W-1:0]          rem_q, dvsr_q;
	logic [KB_W:0]            trial;
	logic                     ge;
	logic [QW-1:0]            quo_q;
	logic                     sat_q;
	logic [IT_W-1:0]          it_q;
	logic [CW-1:0]            span;

	logic [QW-1:0]            chi_q;
	logic [GW-1:0]            gap_q;

	logic                     out_valid_q;
	logic [OW-1:0]            samp_o, match_o;
	logic [GW-1:0]            gap_o;
	logic [QW-1:0]            chi_o;

	assign cw        = rngqc_pkg::ucode(pc_q);
	assign out_busy  = out_valid_q && !m_axis_tready;
	assign emit_fire = busy_q && (cw.op == rngqc_pkg::OP_EMIT) && !out_busy;

	always_comb begin
		case (cw.jmp)
			rngqc_pkg::JMP_BINS: take = !last_bin_q;
			rngqc_pkg::JMP_DIV:  take = (it_q != IT_W'(1));
			rngqc_pkg::JMP_OUT:  take = out_busy;
			default:             take = 1'b0;
		endcase
	end

	assign kb      = KB_W'(count_rd) * KB_W'(NUM_BINS);
	assign nn      = KB_W'(samples_q);
	assign diff_nx = (kb >= nn) ? kb - nn : nn - kb;

	// diff = h*2^HW + l; diff^2 = l*l + (h*l)<<(HW+1) + (h*h)<<(2*HW)
	assign op_h = HW'(diff_q >> HW);
	assign op_l = diff_q[HW-1:0];

	always_comb begin
		case (cw.mul)
			rngqc_pkg::MUL_HL: begin
				ma = op_h;
				mb = op_l;
			end
			rngqc_pkg::MUL_HH: begin
				ma = op_h;
				mb = op_h;
			end
			default: begin
				ma = op_l;
				mb = op_l;
			end
		endcase
	end

	always_comb begin
		case (cw.acc)
			rngqc_pkg::ACC_LL: term = TW'(prod_q);
			rngqc_pkg::ACC_HL: term = TW'(prod_q) << (HW + 1);
			rngqc_pkg::ACC_HH: term = TW'(prod_q) << (2 * HW);
			default:           term = '0;
		endcase
	end

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, dvsr_q};
	assign span  = latest_q - first_q;

	// Control and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= rngqc_pkg::PC_PRIME;
			samples_q  <= '0;
			matches_q  <= '0;
			first_q    <= '0;
			latest_q   <= '0;
			prev_q     <= '0;
			lbp_q      <= '0;
			wr_s1_q    <= 1'b0;
			vld_q      <= '0;
			byp_q      <= 1'b0;
			hit_q      <= 1'b0;
			bin_cnt_q  <= '0;
			last_bin_q <= 1'b0;
			acc_q      <= '0;
			rem_q      <= '0;
			dvsr_q     <= '0;
			sat_q      <= 1'b0;
			it_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			wr_s1_q <= s_fire;
			byp_q   <= wr_s1_q && (rd_addr == bin_s1);
			hit_q   <= vld_q[rd_addr];
			if (wr_s1_q) begin
				vld_q[bin_s1] <= 1'b1;
			end

			if (s_fire) begin
				if (match) begin
					if (matches_q == '0) begin
						first_q <= samples_q - CW'(2);
					end
					latest_q  <= samples_q - CW'(2);
					matches_q <= sat_inc(matches_q);
				end
				lbp_q     <= prev_q;
				prev_q    <= letter;
				samples_q <= sat_inc(samples_q);
				if (s_axis_tlast) begin
					busy_q <= 1'b1;
				end
			end else if (emit_fire) begin
				busy_q    <= 1'b0;
				samples_q <= '0;
				matches_q <= '0;
				first_q   <= '0;
				latest_q  <= '0;
				prev_q    <= '0;
				lbp_q     <= '0;
				vld_q     <= '0;
				acc_q     <= '0;
			end

			if (busy_q) begin
				if (take) begin
					pc_q <= cw.tgt;
				end else if (cw.op == rngqc_pkg::OP_EMIT) begin
					pc_q <= rngqc_pkg::PC_PRIME;
				end else begin
					pc_q <= pc_q + rngqc_pkg::PC_W'(1);
				end

				if (cw.acc != rngqc_pkg::ACC_NONE) begin
					acc_q <= acc_q + term[SW-1:0];
				end

				case (cw.op)
					rngqc_pkg::OP_DIFF: begin
						last_bin_q <= (bin_cnt_q == IW'(NUM_BINS - 1));
						bin_cnt_q  <= (bin_cnt_q == IW'(NUM_BINS - 1)) ? '0 :
						              bin_cnt_q + IW'(1);
					end
					rngqc_pkg::OP_LOAD_CHI: begin
						rem_q  <= '0;
						dvsr_q <= KB_W'(samples_q) * KB_W'(NUM_BINS);
						sat_q  <= 1'b0;
						it_q   <= IT_W'(NUM_W);
					end
					rngqc_pkg::OP_LOAD_GAP: begin
						rem_q  <= '0;
						dvsr_q <= KB_W'(matches_q - CW'(1));
						sat_q  <= 1'b0;
						it_q   <= IT_W'(NUM_W);
					end
					rngqc_pkg::OP_DIV: begin
						rem_q <= ge ? KB_W'(trial - {1'b0, dvsr_q}) : KB_W'(trial);
						// a one leaving the quotient register means overflow
						sat_q <= sat_q | quo_q[QW-1];
						it_q  <= it_q - IT_W'(1);
					end
					default: ;
				endcase
			end

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath payload
	always_ff @(posedge clk) begin
		if (busy_q) begin
			if (cw.mul != rngqc_pkg::MUL_NONE) begin
				prod_q <= ma * mb;
			end
			case (cw.op)
				rngqc_pkg::OP_DIFF: begin
					diff_q <= diff_nx;
				end
				rngqc_pkg::OP_LOAD_CHI: begin
					num_q <= {acc_q, {rngqc_pkg::CHI_FRAC{1'b0}}};
					quo_q <= '0;
				end
				rngqc_pkg::OP_LOAD_GAP: begin
					num_q <= NUM_W'({span, {rngqc_pkg::GAP_FRAC{1'b0}}});
					quo_q <= '0;
				end
				rngqc_pkg::OP_DIV: begin
					num_q <= num_q << 1;
					quo_q <= {quo_q[QW-2:0], ge};
				end
				rngqc_pkg::OP_SAVE_CHI: begin
					chi_q <= sat_q ? rngqc_pkg::CHI_MAX : quo_q;
				end
				rngqc_pkg::OP_SAVE_GAP: begin
					if (matches_q > CW'(1)) begin
						gap_q <= (sat_q || (quo_q[QW-1:GW] != '0)) ?
						         rngqc_pkg::GAP_MAX : quo_q[GW-1:0];
					end else begin
						gap_q <= '0;
					end
				end
				default: ;
			endcase
		end
		if (emit_fire) begin
			samp_o  <= fit_total(samples_q);
			match_o <= fit_total(matches_q);
			gap_o   <= gap_q;
			chi_o   <= chi_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{rngqc_pkg::M_PAD_W{1'b0}}, chi_o, gap_o, match_o, samp_o};

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_take_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |-> (pc_q == rngqc_pkg::PC_PRIME))
		else $error("sample transfer while sequencer is running");

	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && s_axis_tlast) |=> busy_q)
		else $error("last sample did not start the result sequence");

	a_result_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($fell(busy_q) && (samples_q == '0)))
		else $error("result shown without closing the run");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dvsr_q != '0) |-> (rem_q < dvsr_q))
		else $error("divider remainder not below divisor");

endmodule

@@ dv/tb_rng_quality_chi_square_cat_test_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rng_quality_chi_square_cat_test_top: self-checking bench for the checker
// Streams runs of samples through the block under several register settings,
// predicts every run summary (sample count, pattern hits, mean hit gap,
// chi-square) in the bench and compares each result transfer field by field.
// Both stream sides idle at random outside steady phases; the result side
// also holds off once for a long stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_rng_quality_chi_square_cat_test_top;

	localparam int TOTAL_W    = rngqc_pkg::TOTAL_W;
	localparam int GAP_W      = rngqc_pkg::GAP_W;
	localparam int CHI_W      = rngqc_pkg::CHI_W;
	localparam int REG_W      = rngqc_pkg::REG_W;
	localparam int APB_AW     = rngqc_pkg::APB_AW;
	localparam int APB_DW     = rngqc_pkg::APB_DW;
	localparam int SAMPLE_W   = rngqc_pkg::SAMPLE_W;
	localparam int M_TDATA_W  = rngqc_pkg::M_TDATA_W;
	localparam int M_PAD_W    = rngqc_pkg::M_PAD_W;

	localparam int BINS       = 10;
	localparam int HIT_LSB    = TOTAL_W;
	localparam int GAP_LSB    = 2 * TOTAL_W;
	localparam int CHI_LSB    = GAP_LSB + GAP_W;
	localparam int WDOG_LIMIT = 4000;
	localparam int HOLD_LEN   = 700;
	localparam logic [TOTAL_W-1:0] CNT_MAX = '1;

	typedef struct packed {
		logic [31:0] smp;
		logic        lst;
	} item_t;

	typedef struct packed {
		logic [CHI_W-1:0]   chi;
		logic [GAP_W-1:0]   gap;
		logic [TOTAL_W-1:0] hits;
		logic [TOTAL_W-1:0] count;
	} summary_t;

	logic clk;
	logic arst_n = 1'b0;

	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_AW-1:0]     paddr   = '0;
	logic [APB_DW-1:0]     pwdata  = '0;
	logic [APB_DW-1:0]     prdata;
	logic                  pready;

	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;
	logic                  s_axis_tlast  = 1'b0;

	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_axis_tdata;

	rng_quality_chi_square_cat_test_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// bench copy of registers and run state
	logic [REG_W-1:0]   alpha, pat_a, pat_b, pat_c;
	logic [TOTAL_W-1:0] bin_tally [BINS];
	logic [TOTAL_W-1:0] run_len, hit_cnt, first_hit, latest_hit;
	logic [REG_W-1:0]   prev_ltr, prev2_ltr;

	item_t    sample_q [$];
	summary_t summary_q [$];
	summary_t want;
	item_t    nxt;

	int  err_count    = 0;
	int  runs_checked = 0;
	int  samples_sent = 0;
	longint hits_seen = 0;
	int  settings     = 0;
	int  idle_cycles  = 0;
	int  hold_left    = 0;
	bit  hold_done    = 1'b0;
	bit  steady       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	task automatic clear_run();
		for (int i = 0; i < BINS; i++)
			bin_tally[i] = '0;
		run_len    = '0;
		hit_cnt    = '0;
		first_hit  = '0;
		latest_hit = '0;
		prev_ltr   = '0;
		prev2_ltr  = '0;
	endtask

	// floor(2^16 * sum (10*b - N)^2 / (10*N)), saturating
	function automatic logic [CHI_W-1:0] chi_stat();
		logic [127:0] acc;
		logic [143:0] num, quo;
		logic [63:0]  kb, diff, dvs;
		acc = '0;
		for (int i = 0; i < BINS; i++) begin
			kb   = 64'd10 * {33'b0, bin_tally[i]};
			diff = (kb >= {33'b0, run_len}) ? kb - {33'b0, run_len} : {33'b0, run_len} - kb;
			acc  = acc + {64'b0, diff} * {64'b0, diff};
		end
		dvs = 64'd10 * {33'b0, run_len};
		if (dvs == 0)
			return '0;
		num = {acc, 16'b0};
		quo = num / {80'b0, dvs};
		if (quo > {92'b0, rngqc_pkg::CHI_MAX})
			return rngqc_pkg::CHI_MAX;
		return quo[CHI_W-1:0];
	endfunction

	// bins the sample, advances the letter search, closes the run on last
	task automatic tally_sample(input logic [31:0] smp, input logic lst);
		logic [63:0]      bin, prod, gap;
		logic [31:0]      ltr_w;
		logic [REG_W-1:0] ltr;
		summary_t         res;
		bin = ({32'b0, smp} * 64'd10) >> 32;
		if (bin >= BINS)
			bin = BINS - 1;
		bin_tally[bin] = sat_inc(bin_tally[bin]);
		prod  = {32'b0, smp} * {57'b0, alpha};
		ltr_w = prod[63:32] + {31'b0, prod[31:0] != 0};
		ltr   = ltr_w[REG_W-1:0];
		if (run_len >= 2 && prev2_ltr == pat_a && prev_ltr == pat_b && ltr == pat_c) begin
			if (hit_cnt == 0)
				first_hit = run_len - 2;
			latest_hit = run_len - 2;
			hit_cnt = sat_inc(hit_cnt);
		end
		prev2_ltr = prev_ltr;
		prev_ltr  = ltr;
		run_len   = sat_inc(run_len);
		if (lst) begin
			gap = '0;
			if (hit_cnt > 1) begin
				gap = ({33'b0, latest_hit - first_hit} << 8) / {33'b0, hit_cnt - 1'b1};
				if (gap > {25'b0, rngqc_pkg::GAP_MAX})
					gap = {25'b0, rngqc_pkg::GAP_MAX};
			end
			res.count = run_len;
			res.hits  = hit_cnt;
			res.gap   = gap[GAP_W-1:0];
			res.chi   = chi_stat();
			summary_q.push_back(res);
			clear_run();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_v);
		err_count++;
		$display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_v);
	endtask

	// a sample whose letter is ltr under the current alphabet size
	function automatic logic [31:0] sample_for_letter(input int unsigned ltr);
		logic [63:0] lo, hi;
		if (alpha == 0)
			return $urandom;
		if (ltr == 0)
			return '0;
		if (ltr > alpha)
			return $urandom;
		hi = ({32'b0, ltr} << 32) / {57'b0, alpha};
		lo = ({32'b0, ltr - 1} << 32) / {57'b0, alpha} + 1;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		return 32'(lo + {32'b0, $urandom} % (hi - lo + 1));
	endfunction

	function automatic logic [31:0] edge_sample();
		logic [63:0] e;
		e = ({32'b0, $urandom_range(1, 9)} << 32) / 64'd10;
		return 32'(e + $urandom_range(0, 1));
	endfunction

	task automatic push_item(input logic [31:0] smp, input logic lst);
		item_t it;
		it.smp = smp;
		it.lst = lst;
		sample_q.push_back(it);
	endtask

	task automatic apb_write(input logic [1:0] idx, input logic [REG_W-1:0] val);
		logic [APB_DW-1:0] wd;
		wd = $urandom;
		wd[REG_W-1:0] = val;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= wd;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			rngqc_pkg::REG_ALPHA: alpha = val;
			rngqc_pkg::REG_PAT1:  pat_a = val;
			rngqc_pkg::REG_PAT2:  pat_b = val;
			rngqc_pkg::REG_PAT3:  pat_c = val;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || s_axis_tvalid || summary_q.size() != 0);
	endtask

	// random runs: mostly short, some medium, a few long; pattern-heavy content
	task automatic queue_runs(input int n_items);
		logic [31:0] burst [$];
		int added, len, pick, top;
		added = 0;
		top = (alpha > 125) ? 127 : alpha + 2;
		while (added < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 65)
				len = $urandom_range(1, 24);
			else if (pick < 95)
				len = $urandom_range(25, 80);
			else
				len = $urandom_range(150, 260);
			burst.delete();
			while (burst.size() < len) begin
				pick = $urandom_range(0, 99);
				if (pick < 22) begin
					burst.push_back(sample_for_letter(pat_a));
					burst.push_back(sample_for_letter(pat_b));
					burst.push_back(sample_for_letter(pat_c));
				end else if (pick < 28) begin
					// pattern cut short
					burst.push_back(sample_for_letter(pat_a));
					burst.push_back(sample_for_letter(pat_b));
				end else if (pick < 48) begin
					burst.push_back(sample_for_letter($urandom_range(0, top)));
				end else if (pick < 56) begin
					case ($urandom_range(0, 2))
						0: burst.push_back(32'h0);
						1: burst.push_back(32'hFFFF_FFFF);
						default: burst.push_back(edge_sample());
					endcase
				end else begin
					burst.push_back($urandom);
				end
			end
			foreach (burst[i])
				push_item(burst[i], i == burst.size() - 1);
			added += burst.size();
		end
	endtask

	task automatic run_phase(input logic [REG_W-1:0] a, input logic [REG_W-1:0] p1,
			input logic [REG_W-1:0] p2, input logic [REG_W-1:0] p3, input int n_items,
			input bit stdy);
		wait_drained();
		repeat (8) @(posedge clk);
		apb_write(rngqc_pkg::REG_ALPHA, a);
		apb_write(rngqc_pkg::REG_PAT1, p1);
		apb_write(rngqc_pkg::REG_PAT2, p2);
		apb_write(rngqc_pkg::REG_PAT3, p3);
		@(negedge clk);
		steady = stdy;
		settings++;
		queue_runs(n_items);
	endtask

	// driver: offer the next pending sample whenever the slot frees up
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				tally_sample(s_axis_tdata, s_axis_tlast);
				samples_sent++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (sample_q.size() != 0 && (steady || $urandom_range(0, 99) >= 19)) begin
					nxt = sample_q.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.smp;
					s_axis_tlast  <= nxt.lst;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each result transfer against the oldest predicted summary
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (summary_q.size() == 0) begin
					report_mismatch("result with none pending", m_axis_tdata[63:0], '0);
				end else begin
					want = summary_q.pop_front();
					if (m_axis_tdata[TOTAL_W-1:0] !== want.count)
						report_mismatch("sample_total", m_axis_tdata[TOTAL_W-1:0], want.count);
					if (m_axis_tdata[HIT_LSB +: TOTAL_W] !== want.hits)
						report_mismatch("match_total", m_axis_tdata[HIT_LSB +: TOTAL_W],
							want.hits);
					if (m_axis_tdata[GAP_LSB +: GAP_W] !== want.gap)
						report_mismatch("mean_gap", m_axis_tdata[GAP_LSB +: GAP_W], want.gap);
					if (m_axis_tdata[CHI_LSB +: CHI_W] !== want.chi)
						report_mismatch("chi_square", m_axis_tdata[CHI_LSB +: CHI_W], want.chi);
					if (m_axis_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0)
						report_mismatch("pad bits", m_axis_tdata[M_TDATA_W-1 -: M_PAD_W], '0);
					runs_checked++;
					hits_seen += want.hits;
				end
			end
			if (hold_left != 0)
				m_axis_tready <= 1'b0;
			else
				m_axis_tready <= steady || ($urandom_range(0, 99) >= 19);
		end
	end

	// one long hold-off on the result side while samples keep coming
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && runs_checked >= 8 && sample_q.size() > 40) begin
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(psel && penable))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		alpha = rngqc_pkg::ALPHA_RST;
		pat_a = rngqc_pkg::PAT1_RST;
		pat_b = rngqc_pkg::PAT2_RST;
		pat_c = rngqc_pkg::PAT3_RST;
		clear_run();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		settings = 1;

		// directed, reset settings: single-sample run, extremes and bin edges
		push_item(32'h0, 1'b1);
		push_item(32'hFFFF_FFFF, 1'b0);
		push_item(32'h1999_9999, 1'b0);
		push_item(32'h1999_999A, 1'b1);
		push_item(32'h8000_0000, 1'b0);
		push_item(32'hE666_6666, 1'b1);
		// pattern at run start, three hits with equal gaps, last hit ends the run
		push_item(sample_for_letter(pat_a), 1'b0);
		push_item(sample_for_letter(pat_b), 1'b0);
		push_item(sample_for_letter(pat_c), 1'b0);
		push_item($urandom, 1'b0);
		push_item(sample_for_letter(pat_a), 1'b0);
		push_item(sample_for_letter(pat_b), 1'b0);
		push_item(sample_for_letter(pat_c), 1'b0);
		push_item(sample_for_letter(5), 1'b0);
		push_item(sample_for_letter(pat_a), 1'b0);
		push_item(sample_for_letter(pat_b), 1'b0);
		push_item(sample_for_letter(pat_c), 1'b1);

		run_phase(7'd2,   7'd1,   7'd2,   7'd1,   300, 1'b0);
		run_phase(7'd64,  7'd64,  7'd0,   7'd64,  250, 1'b1);
		// every letter is zero: overlapping hits on each triple
		run_phase(7'd0,   7'd0,   7'd0,   7'd0,   200, 1'b0);
		run_phase(7'd1,   7'd1,   7'd1,   7'd0,   250, 1'b0);
		run_phase(7'd127, 7'd100, 7'd120, 7'd127, 200, 1'b0);
		for (int k = 0; k < 3; k++) begin
			int a;
			a = $urandom_range(2, 64);
			run_phase(7'(a), 7'($urandom_range(0, a + 2)), 7'($urandom_range(0, a + 2)),
				7'($urandom_range(0, a + 2)), 250, 1'b0);
		end

		wait_drained();
		repeat (300) @(posedge clk);
		$display("Covered %0d runs, %0d samples, %0d pattern hits over %0d register settings",
			runs_checked, samples_sent, hits_seen, settings);
		$display("Result side held off once for %0d cycles: %s", HOLD_LEN,
			hold_done ? "done" : "not reached");
		if (err_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", err_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
